// ===== design/fixed_block_free_list_allocator_assert.svh =====
// Assertion macros shared by the free list allocator checkers.
// Expects clk and rst to be visible where the macros are used.
`ifndef FIXED_BLOCK_FREE_LIST_ALLOCATOR_ASSERT_SVH
`define FIXED_BLOCK_FREE_LIST_ALLOCATOR_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst is high.
`define FBFL_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("fbfl: same-cycle check failed");

// Next-cycle implication, sampled on clk, off while rst is high.
`define FBFL_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("fbfl: next-cycle check failed");

`endif

// ===== design/fbfl_pkg.sv =====
// Package for the fixed block free list allocator.
// Opcode and status codes, default sizes, and the request decode record.
`timescale 1ns / 1ps
`default_nettype none

package fbfl_pkg;

  localparam int BLOCK_COUNT_DEF = 512;
  localparam int BLOCK_BYTES_DEF = 4096;
  localparam int MAX_ALIGN_DEF   = 16;

  // Width of a block index on the ports.
  localparam int IDX_W = 9;

  typedef enum logic [1:0] {
    OP_ALLOC  = 2'd0,
    OP_FREE   = 2'd1,
    OP_RESIZE = 2'd2,
    OP_REINIT = 2'd3
  } opcode_t;

  typedef enum logic [2:0] {
    ST_OK            = 3'd0,
    ST_EXHAUSTED     = 3'd1,
    ST_TOO_LARGE     = 3'd2,
    ST_FREE_OVERFLOW = 3'd3,
    ST_NULL_FREE     = 3'd4
  } status_t;

  // Decode of one request, carried from the stack unit to the result stage.
  typedef struct packed {
    status_t                status;
    logic                   pop;        // allocate succeeded
    logic                   fresh;      // popped slot never written since refill
    logic [IDX_W-1:0]       fresh_idx;  // value such a slot holds
  } req_info_t;

endpackage

`default_nettype wire

// ===== design/fbfl_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module fbfl_ram #(
  parameter int WIDTH = 9,
  parameter int DEPTH = 512
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== design/fbfl_stack.sv =====
// Free stack: fill count, low-water mark, request decode and the stack RAM.
// Uses fbfl_pkg and fbfl_ram.
`timescale 1ns / 1ps
`default_nettype none

module fbfl_stack import fbfl_pkg::*; #(
  parameter int BLOCK_COUNT = BLOCK_COUNT_DEF,
  parameter int BLOCK_BYTES = BLOCK_BYTES_DEF,
  parameter int MAX_ALIGN   = MAX_ALIGN_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             accept,
  input  wire logic [1:0]       opcode,
  input  wire logic [15:0]      request_length,
  input  wire logic [11:0]      alignment,
  input  wire logic             has_block,
  input  wire logic [IDX_W-1:0] block_in,
  output req_info_t             info,
  output logic      [IDX_W-1:0] rd_data
);

  localparam int AW = $clog2(BLOCK_COUNT);
  localparam int CW = $clog2(BLOCK_COUNT + 1);
  localparam int EW = (CW > IDX_W) ? CW : IDX_W;
  localparam logic [CW-1:0] FULL = CW'(BLOCK_COUNT);

  // count: free entries. low_mark: lowest count since the last refill;
  // slots below it still hold their refill value (slot k holds k).
  logic [CW-1:0] count, count_next;
  logic [CW-1:0] low_mark, low_mark_next;
  logic [CW-1:0] count_m1;
  logic [EW-1:0] count_m1_ext;
  logic          too_large, unnamed, push;

  assign count_m1     = count - CW'(1);
  assign count_m1_ext = EW'(count_m1);
  assign too_large    = (request_length > 16'(BLOCK_BYTES)) ||
                        (alignment > 12'(MAX_ALIGN));
  assign unnamed      = !has_block || (32'(block_in) >= 32'(BLOCK_COUNT));

  always_comb begin
    info.status    = ST_OK;
    info.pop       = 1'b0;
    info.fresh     = (count == low_mark);
    info.fresh_idx = count_m1_ext[IDX_W-1:0];
    push           = 1'b0;
    count_next     = count;
    low_mark_next  = low_mark;
    unique case (opcode_t'(opcode))
      OP_ALLOC: begin
        if (too_large) begin
          info.status = ST_TOO_LARGE;
        end else if (count == '0) begin
          info.status = ST_EXHAUSTED;
        end else begin
          info.pop   = 1'b1;
          count_next = count_m1;
          if (count == low_mark) begin
            low_mark_next = count_m1;
          end
        end
      end
      OP_FREE: begin
        if (unnamed) begin
          info.status = ST_NULL_FREE;
        end else if (count == FULL) begin
          info.status = ST_FREE_OVERFLOW;
        end else begin
          push       = 1'b1;
          count_next = count + CW'(1);
        end
      end
      OP_RESIZE: begin
        info.status = (request_length > 16'(BLOCK_BYTES)) ? ST_TOO_LARGE : ST_OK;
      end
      OP_REINIT: begin
        count_next    = FULL;
        low_mark_next = FULL;
      end
      default: begin
        info.status = ST_OK;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= FULL;
      low_mark <= FULL;
    end else if (accept) begin
      count    <= count_next;
      low_mark <= low_mark_next;
    end
  end

  fbfl_ram #(
    .WIDTH (IDX_W),
    .DEPTH (BLOCK_COUNT)
  ) u_ram (
    .clk   (clk),
    .we    (accept && push),
    .waddr (count[AW-1:0]),
    .wdata (block_in),
    .re    (accept && info.pop),
    .raddr (count_m1[AW-1:0]),
    .rdata (rd_data)
  );

endmodule

`default_nettype wire

// ===== design/fixed_block_free_list_allocator.sv =====
// Top level of the fixed block free list allocator.
// Uses fbfl_pkg and fbfl_stack (which holds the stack RAM).
//
//  channel | signals                                          | dir
//  --------+--------------------------------------------------+-----
//  in      | in_valid, in_stall, opcode, request_length,      | in
//          | alignment, has_block, block_in                   |
//  out     | out_valid, out_stall, status, block_out          | out
//
// One beat in and one beat out per cycle sustained while out_stall is low;
// every request yields exactly one result beat, via the decode stage and then the output register.
// The popped index is read from the single stack RAM read port at accept
// and lands in the output register when the decode stage moves on.
// rst (synchronous) empties both stages and refills the stack via the
// low-water mark; reinitialise refills the stack the same way.
// in_stall is high only when the decode stage and the output register are
// both full and out_stall holds the output.
`timescale 1ns / 1ps
`default_nettype none

module fixed_block_free_list_allocator import fbfl_pkg::*; #(
  parameter int BLOCK_COUNT = BLOCK_COUNT_DEF,
  parameter int BLOCK_BYTES = BLOCK_BYTES_DEF,
  parameter int MAX_ALIGN   = MAX_ALIGN_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire logic [1:0]       opcode,
  input  wire logic [15:0]      request_length,
  input  wire logic [11:0]      alignment,
  input  wire logic             has_block,
  input  wire logic [IDX_W-1:0] block_in,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output logic      [2:0]       status,
  output logic      [IDX_W-1:0] block_out
);

  req_info_t        info;
  req_info_t        s1_info;
  logic             s1_valid;
  logic [IDX_W-1:0] rd_data;
  logic             accept;
  logic             s1_move;
  logic [IDX_W-1:0] s1_block;

  // Decode stage moves on whenever the output register is free or draining.
  assign s1_move  = s1_valid && (!out_valid || !out_stall);
  assign in_stall = s1_valid && !s1_move;
  assign accept   = in_valid && !in_stall;

  fbfl_stack #(
    .BLOCK_COUNT (BLOCK_COUNT),
    .BLOCK_BYTES (BLOCK_BYTES),
    .MAX_ALIGN   (MAX_ALIGN)
  ) u_stack (
    .clk            (clk),
    .rst            (rst),
    .accept         (accept),
    .opcode         (opcode),
    .request_length (request_length),
    .alignment      (alignment),
    .has_block      (has_block),
    .block_in       (block_in),
    .info           (info),
    .rd_data        (rd_data)
  );

  // RAM data is held until the next pop, which can only be taken on the
  // edge where this stage empties, so rd_data is good while s1 waits.
  always_comb begin
    if (!s1_info.pop) begin
      s1_block = '0;
    end else if (s1_info.fresh) begin
      s1_block = s1_info.fresh_idx;
    end else begin
      s1_block = rd_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid <= 1'b1;
      end else if (s1_move) begin
        s1_valid <= 1'b0;
      end
      if (s1_move) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_info <= info;
    end
    if (s1_move) begin
      status    <= s1_info.status;
      block_out <= s1_block;
    end
  end

endmodule

`default_nettype wire

// ===== design/fbfl_checker.sv =====
// Port-level checker for the free list allocator, bound to the top level.
// Uses fbfl_pkg and fixed_block_free_list_allocator_assert.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "fixed_block_free_list_allocator_assert.svh"

module fbfl_checker import fbfl_pkg::*; (
  input wire logic             clk,
  input wire logic             rst,
  input wire logic             in_valid,
  input wire logic             in_stall,
  input wire logic [1:0]       opcode,
  input wire logic [15:0]      request_length,
  input wire logic [11:0]      alignment,
  input wire logic             has_block,
  input wire logic [IDX_W-1:0] block_in,
  input wire logic             out_valid,
  input wire logic             out_stall,
  input wire logic [2:0]       status,
  input wire logic [IDX_W-1:0] block_out
);

  // A held result beat keeps its payload.
  `FBFL_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(status) && $stable(block_out))

  // Input backpressure only comes from a stalled, full output.
  `FBFL_ASSERT_NOW(a_stall_cause, in_stall, out_valid && out_stall)

  // A nonzero index is only reported with a good status.
  `FBFL_ASSERT_NOW(a_block_ok, out_valid && (block_out != '0), status == ST_OK)

endmodule

bind fixed_block_free_list_allocator fbfl_checker u_fbfl_checker (.*);

`default_nettype wire
